[rtl/pli_pkg.sv]
// pli_pkg: shared constants, codes and types for the positional list
// no dependencies
`default_nettype none
package pli_pkg;
	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int POS_W    = 5;
	localparam int ENT_W    = 5;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CW       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [2:0] {
		K_INS_POS   = 3'd0,
		K_INS_FRONT = 3'd1,
		K_INS_END   = 3'd2,
		K_DEL_POS   = 3'd3,
		K_DEL_FRONT = 3'd4,
		K_DUMP      = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		S_OK     = 2'd0,
		S_BADPOS = 2'd1,
		S_EMPTY  = 2'd2,
		S_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INS,
		CM_DEL,
		CM_ROT
	} cell_mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	typedef struct packed {
		cell_mode_t               mode;
		logic [IDX_W-1:0]         pos;
		logic [CNT_W-1:0]         fill;
		logic signed [KEY_W-1:0]  key;
	} cell_cmd_t;
endpackage
`default_nettype wire

[rtl/pli_in_if.sv]
// pli_in_if: command channel, valid/ready with kind, position and key
// depends on pli_pkg
`default_nettype none
interface pli_in_if
	import pli_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [2:0]              kind;
	logic [POS_W-1:0]        position;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, kind, position, key, input ready);
	modport sink (input valid, kind, position, key, output ready);
endinterface
`default_nettype wire

[rtl/pli_out_if.sv]
// pli_out_if: result channel, valid/ready with status, key, count and last flag
// depends on pli_pkg
`default_nettype none
interface pli_out_if
	import pli_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic signed [KEY_W-1:0] key_out;
	logic [ENT_W-1:0]        entries_held;
	logic                    last;

	modport source (output valid, status, key_out, entries_held, last, input ready);
	modport sink (input valid, status, key_out, entries_held, last, output ready);
endinterface
`default_nettype wire

[rtl/positional_list_insert_delete_top.sv]
// positional_list_insert_delete_top: chain of key cells under one controller
// depends on pli_pkg, pli_in_if, pli_out_if, pli_cell, pli_ctrl
// results are registered; a dump enters its dump state before its first key is loaded
// insert, delete and rejected commands: one beat per cycle while results drain
// dump: one key per cycle while results drain, by cell ring rotation, commands held off
// reset: fill count and controller cleared; stored keys are not reset
`default_nettype none
module positional_list_insert_delete_top
	import pli_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	pli_in_if.sink    cmd,
	pli_out_if.source rsp
);
	cell_cmd_t               cc;
	logic signed [KEY_W-1:0] keys [CAPACITY];

	pli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.head   (keys[0]),
		.cc     (cc)
	);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [KEY_W-1:0] lft, rgt;
		if (g == 0) begin : g_first
			assign lft = cc.key;
		end else begin : g_mid_l
			assign lft = keys[g-1];
		end
		if (g == CAPACITY - 1) begin : g_end
			assign rgt = keys[0];
		end else begin : g_mid_r
			assign rgt = keys[g+1];
		end
		pli_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.cmd   (cc),
			.left  (lft),
			.right (rgt),
			.head  (keys[0]),
			.key_q (keys[g])
		);
	end
endmodule
`default_nettype wire

[rtl/pli_cell.sv]
// pli_cell: one list slot; holds, loads, or takes its left or right neighbor or the head key
// depends on pli_pkg
`default_nettype none
module pli_cell
	import pli_pkg::*;
(
	input  wire                     clk,
	input  wire [IDX_W-1:0]         idx,
	input  wire cell_cmd_t          cmd,
	input  wire signed [KEY_W-1:0]  left,
	input  wire signed [KEY_W-1:0]  right,
	input  wire signed [KEY_W-1:0]  head,
	output logic signed [KEY_W-1:0] key_q
);
	logic [CW-1:0] i_w, p_w, f_w;
	logic signed [KEY_W-1:0] key_d;

	assign i_w = CW'(idx);
	assign p_w = CW'(cmd.pos);
	assign f_w = CW'(cmd.fill);

	always_comb begin
		key_d = key_q;
		case (cmd.mode)
			CM_INS: begin
				if (i_w == p_w) begin
					key_d = cmd.key;
				end else if (i_w > p_w && i_w <= f_w) begin
					key_d = left;
				end
			end
			CM_DEL: begin
				if (i_w >= p_w && i_w + CW'(1) < f_w) begin
					key_d = right;
				end
			end
			CM_ROT: begin
				if (i_w + CW'(1) < f_w) begin
					key_d = right;
				end else if (i_w + CW'(1) == f_w) begin
					key_d = head;
				end
			end
			default: key_d = key_q;
		endcase
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end
endmodule
`default_nettype wire

[rtl/pli_ctrl.sv]
// pli_ctrl: command decode, fill count, dump sequencer and result register
// depends on pli_pkg, pli_in_if, pli_out_if
`default_nettype none
module pli_ctrl
	import pli_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	pli_in_if.sink                 cmd,
	pli_out_if.source              rsp,
	input  wire signed [KEY_W-1:0] head,
	output cell_cmd_t              cc
);
	state_t           state_q, state_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic signed [KEY_W-1:0] key_out_q;
	logic [ENT_W-1:0] ent_q;
	logic             last_q;

	logic             slot_free, accept, ld, ld_last;
	status_t          ld_status;
	logic signed [KEY_W-1:0] ld_key;
	logic [CW-1:0]    pos_w, fill_w;

	assign slot_free = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && slot_free;
	assign accept    = cmd.valid && cmd.ready;
	assign pos_w     = CW'(cmd.position);
	assign fill_w    = CW'(fill_q);

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		cnt_d     = cnt_q;
		ld        = 1'b0;
		ld_status = S_OK;
		ld_key    = '0;
		ld_last   = 1'b1;
		cc.mode   = CM_HOLD;
		cc.pos    = '0;
		cc.fill   = fill_q;
		cc.key    = cmd.key;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.kind)
						K_INS_POS, K_INS_FRONT, K_INS_END: begin
							ld = 1'b1;
							if (fill_q == CNT_W'(CAPACITY)) begin
								ld_status = S_FULL;
							end else if (cmd.kind == K_INS_FRONT) begin
								cc.mode = CM_INS;
							end else if (cmd.kind == K_INS_END) begin
								cc.mode = CM_INS;
								cc.pos  = IDX_W'(fill_q);
							end else if (pos_w < CW'(1) || pos_w > fill_w + CW'(1)) begin
								ld_status = S_BADPOS;
							end else begin
								cc.mode = CM_INS;
								cc.pos  = IDX_W'(pos_w - CW'(1));
							end
							if (cc.mode == CM_INS) begin
								fill_d = fill_q + CNT_W'(1);
							end
						end
						K_DEL_POS, K_DEL_FRONT: begin
							ld = 1'b1;
							if (fill_q == '0) begin
								ld_status = S_EMPTY;
							end else if (cmd.kind == K_DEL_FRONT) begin
								cc.mode = CM_DEL;
							end else if (pos_w < CW'(1) || pos_w > fill_w) begin
								ld_status = S_BADPOS;
							end else begin
								cc.mode = CM_DEL;
								cc.pos  = IDX_W'(pos_w - CW'(1));
							end
							if (cc.mode == CM_DEL) begin
								fill_d = fill_q - CNT_W'(1);
							end
						end
						K_DUMP: begin
							if (fill_q == '0) begin
								ld        = 1'b1;
								ld_status = S_EMPTY;
							end else begin
								state_d = ST_DUMP;
								cnt_d   = '0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_DUMP: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_key  = head;
					ld_last = (CNT_W'(cnt_q) + CNT_W'(1) == fill_q);
					cc.mode = CM_ROT;
					cnt_d   = cnt_q + IDX_W'(1);
					if (ld_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			cnt_q   <= cnt_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			status_q  <= ld_status;
			key_out_q <= ld_key;
			ent_q     <= ENT_W'(fill_d);
			last_q    <= ld_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.key_out      = key_out_q;
	assign rsp.entries_held = ent_q;
	assign rsp.last         = last_q;

	// fill never passes the capacity
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill above capacity");

	// no command is taken while a dump streams
	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> !cmd.ready)
		else $error("command taken during dump");

	// dump position stays inside the list
	a_dump_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> CNT_W'(cnt_q) < fill_q)
		else $error("dump index out of range");

	// a successful insert grows the list by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cc.mode == CM_INS |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("insert did not grow fill");

	// the fill count stays unchanged while a dump runs
	a_dump_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |=> $stable(fill_q))
		else $error("fill changed during dump");
endmodule
`default_nettype wire

[sim/tb.sv]
// tb: self-checking bench for positional_list_insert_delete_top, random and directed commands
// depends on pli_pkg, pli_in_if, pli_out_if and the list rtl
`timescale 1ns / 1ps
module tb;
	import pli_pkg::*;

	localparam logic [2:0] K_UNUSED_LO = 3'd6;
	localparam logic [2:0] K_UNUSED_HI = 3'd7;

	typedef struct {
		logic [2:0]              kind;
		logic [POS_W-1:0]        position;
		logic signed [KEY_W-1:0] key;
	} list_cmd_t;

	typedef struct {
		status_t                 status;
		logic signed [KEY_W-1:0] key_out;
		logic [ENT_W-1:0]        entries_held;
		logic                    last;
	} list_rslt_t;

	logic clk;
	logic arst_n;

	pli_in_if  cmd_if ();
	pli_out_if rsp_if ();

	positional_list_insert_delete_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	list_cmd_t               cmd_pending_q[$];
	list_rslt_t              rslt_expect_q[$];
	logic signed [KEY_W-1:0] shadow_keys[CAPACITY];
	int                      shadow_fill = 0;
	int                      mismatch_cnt = 0;
	int                      send_idle_pct = 0;
	int                      recv_stall_pct = 0;
	logic                    cmd_beat_taken = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("positional_list_insert_delete_top verification failed");
		$finish;
	end

	function void expect_rslt(status_t st, logic signed [KEY_W-1:0] kv, logic fin);
		list_rslt_t r;
		r.status       = st;
		r.key_out      = kv;
		r.entries_held = ENT_W'(shadow_fill);
		r.last         = fin;
		rslt_expect_q.push_back(r);
	endfunction

	// shadow list update and expected results for one command beat
	function void apply_list_cmd(list_cmd_t c);
		int      p;
		int      i;
		status_t st;
		st = S_OK;
		p  = 0;
		case (c.kind)
			K_INS_POS, K_INS_FRONT, K_INS_END: begin
				if (shadow_fill >= CAPACITY) begin
					st = S_FULL;
				end else if (c.kind != K_INS_POS || (c.position >= 1 &&
						c.position <= shadow_fill + 1)) begin
					if (c.kind == K_INS_POS)
						p = c.position - 1;
					else if (c.kind == K_INS_END)
						p = shadow_fill;
					for (i = shadow_fill; i > p; i--)
						shadow_keys[i] = shadow_keys[i-1];
					shadow_keys[p] = c.key;
					shadow_fill++;
				end else begin
					st = S_BADPOS;
				end
				expect_rslt(st, '0, 1'b1);
			end
			K_DEL_POS, K_DEL_FRONT: begin
				if (shadow_fill == 0) begin
					st = S_EMPTY;
				end else if (c.kind == K_DEL_FRONT || (c.position >= 1 &&
						c.position <= shadow_fill)) begin
					if (c.kind == K_DEL_POS)
						p = c.position - 1;
					for (i = p; i + 1 < shadow_fill; i++)
						shadow_keys[i] = shadow_keys[i+1];
					shadow_fill--;
				end else begin
					st = S_BADPOS;
				end
				expect_rslt(st, '0, 1'b1);
			end
			K_DUMP: begin
				if (shadow_fill == 0)
					expect_rslt(S_EMPTY, '0, 1'b1);
				for (i = 0; i < shadow_fill; i++)
					expect_rslt(S_OK, shadow_keys[i], i + 1 == shadow_fill);
			end
			default: ;
		endcase
	endfunction

	function void note_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	// command and result beats
	always @(posedge clk) begin
		list_rslt_t want;
		list_cmd_t  seen;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (rslt_expect_q.size() == 0) begin
					note_mismatch($sformatf("unexpected result status %0d key %0d held %0d last %0b",
						rsp_if.status, rsp_if.key_out, rsp_if.entries_held, rsp_if.last));
				end else begin
					want = rslt_expect_q.pop_front();
					if (rsp_if.status !== want.status || rsp_if.key_out !== want.key_out ||
							rsp_if.entries_held !== want.entries_held ||
							rsp_if.last !== want.last)
						note_mismatch($sformatf(
							"status %0d/%0d key %0d/%0d held %0d/%0d last %0b/%0b (exp/got)",
							want.status, rsp_if.status, want.key_out, rsp_if.key_out,
							want.entries_held, rsp_if.entries_held, want.last, rsp_if.last));
				end
			end
			if (cmd_if.valid && cmd_if.ready) begin
				seen.kind     = cmd_if.kind;
				seen.position = cmd_if.position;
				seen.key      = cmd_if.key;
				apply_list_cmd(seen);
			end
		end
		cmd_beat_taken <= arst_n && cmd_if.valid && cmd_if.ready;
	end

	always @(negedge clk) begin
		list_cmd_t next_cmd;
		if (arst_n && (!cmd_if.valid || cmd_beat_taken)) begin
			if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_cmd = cmd_pending_q.pop_front();
				cmd_if.valid    <= 1'b1;
				cmd_if.kind     <= next_cmd.kind;
				cmd_if.position <= next_cmd.position;
				cmd_if.key      <= next_cmd.key;
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task add_cmd(input logic [2:0] kind, input int pos, input logic signed [KEY_W-1:0] key);
		list_cmd_t c;
		c.kind     = kind;
		c.position = POS_W'(pos);
		c.key      = key;
		cmd_pending_q.push_back(c);
	endtask

	task wait_drained();
		do
			@(posedge clk);
		while (cmd_pending_q.size() != 0 || cmd_if.valid || rslt_expect_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// noise, then a fill to full, a full dump and a drain to empty
	task add_random_round();
		logic [2:0] k;
		int         i;
		repeat (4)
			add_cmd(3'($urandom_range(7)), $urandom_range(31), $urandom);
		for (i = 0; i < CAPACITY; i++) begin
			k = ($urandom_range(2) == 0) ? K_INS_POS :
				($urandom_range(1) ? K_INS_FRONT : K_INS_END);
			add_cmd(k, $urandom_range(i + 1, 1), $urandom);
		end
		add_cmd(K_INS_POS, 0, $urandom);
		add_cmd(K_INS_POS, 31, $urandom);
		add_cmd(K_INS_FRONT, $urandom_range(31), $urandom);
		add_cmd(K_DUMP, $urandom_range(31), $urandom);
		for (i = 0; i < CAPACITY; i++) begin
			if ($urandom_range(1))
				add_cmd(K_DEL_POS, $urandom_range(CAPACITY - i, 1), $urandom);
			else
				add_cmd(K_DEL_FRONT, $urandom_range(31), $urandom);
		end
		add_cmd(K_DEL_POS, 0, $urandom);
		add_cmd(K_DEL_FRONT, $urandom_range(31), $urandom);
		add_cmd(K_DUMP, $urandom_range(31), $urandom);
	endtask

	initial begin
		arst_n          = 1'b0;
		cmd_if.valid    = 1'b0;
		cmd_if.kind     = '0;
		cmd_if.position = '0;
		cmd_if.key      = '0;
		rsp_if.ready    = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty list, edge keys, bad positions, unused kinds
		add_cmd(K_DUMP, 0, 0);
		add_cmd(K_DEL_FRONT, 0, 0);
		add_cmd(K_DEL_POS, 0, 0);
		add_cmd(K_INS_POS, 0, 1);
		add_cmd(K_INS_POS, 2, 2);
		add_cmd(K_INS_POS, 1, 32'sh8000_0000);
		add_cmd(K_INS_FRONT, 0, 32'sh7fff_ffff);
		add_cmd(K_INS_END, 31, -1);
		add_cmd(K_INS_END, 0, 0);
		add_cmd(K_INS_POS, 3, 32'sh5a5a_5a5a);
		add_cmd(K_INS_POS, 6, 32'sha5a5_a5a5);
		add_cmd(K_INS_POS, 31, 3);
		add_cmd(K_DUMP, 0, 0);
		add_cmd(K_DEL_POS, 0, 0);
		add_cmd(K_DEL_POS, 7, 0);
		add_cmd(K_DEL_POS, 31, -1);
		add_cmd(K_UNUSED_LO, 1, 4);
		add_cmd(K_UNUSED_HI, 31, -1);
		add_cmd(K_DEL_POS, 6, 0);
		add_cmd(K_DEL_POS, 2, 0);
		add_cmd(K_DEL_FRONT, 0, 0);
		add_cmd(K_DUMP, 31, -1);
		add_random_round();
		wait_drained();

		send_idle_pct  = 77;
		recv_stall_pct = 0;
		add_random_round();
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 77;
		add_random_round();
		wait_drained();

		send_idle_pct  = 27;
		recv_stall_pct = 27;
		add_random_round();
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && rslt_expect_q.size() == 0) begin
			$display("positional_list_insert_delete_top verification clean");
		end else begin
			$display("positional_list_insert_delete_top verification failed");
		end
		$finish;
	end
endmodule

[files.f]
rtl/pli_pkg.sv
rtl/pli_in_if.sv
rtl/pli_out_if.sv
rtl/pli_cell.sv
rtl/pli_ctrl.sv
rtl/positional_list_insert_delete_top.sv
sim/tb.sv
